>>> design/fmcpvw_pkg.sv
`default_nettype none

package fmcpvw_pkg;

  localparam int CHANNELS = 4;
  localparam int ChW      = 2;

  localparam int FreqW = 14;
  localparam int VolW  = 8;
  localparam int AddrW = 9;
  localparam int DataW = 8;
  localparam int BlkW  = 3;
  localparam int FnumW = 10;

  // floor(N / 49716) for N < 2**NumW via reciprocal multiply plus one correction
  localparam longint unsigned Divisor    = 64'd49716;
  localparam int              NumW       = 26;
  localparam int              RecipShift = 42;
  localparam int              RecipW     = 27;
  localparam longint unsigned Recip      = (64'd1 << RecipShift) / Divisor;
  localparam int              ProdW      = NumW + RecipW;
  localparam int              QW         = ProdW - RecipShift;
  localparam int              RemW       = 27;

  localparam logic [AddrW-1:0] FnumLoBase = 9'h1A5;
  localparam logic [AddrW-1:0] KeyBase    = 9'h1B5;
  localparam logic [DataW-1:0] KeyOnMask  = 8'h20;
  localparam logic [DataW-1:0] KeyOffMask = 8'hDF;

  localparam logic [FreqW-1:0] Thr7 = 14'd6208;
  localparam logic [FreqW-1:0] Thr6 = 14'd3104;
  localparam logic [FreqW-1:0] Thr5 = 14'd1552;
  localparam logic [FreqW-1:0] Thr4 = 14'd776;
  localparam logic [FreqW-1:0] Thr3 = 14'd388;
  localparam logic [FreqW-1:0] Thr2 = 14'd194;
  localparam logic [FreqW-1:0] Thr1 = 14'd97;

  typedef enum logic {
    REQ_FREQ = 1'b0,
    REQ_VOL  = 1'b1
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic             last;
  } beat_t;

  function automatic logic [DataW-1:0] atten_lut(input logic [3:0] idx);
    logic [DataW-1:0] v;
    case (idx)
      4'd0:    v = 8'd0;
      4'd1:    v = 8'd1;
      4'd2:    v = 8'd2;
      4'd3:    v = 8'd3;
      4'd4:    v = 8'd4;
      4'd5:    v = 8'd6;
      4'd6:    v = 8'd8;
      4'd7:    v = 8'd10;
      4'd8:    v = 8'd12;
      4'd9:    v = 8'd16;
      4'd10:   v = 8'd20;
      4'd11:   v = 8'd28;
      4'd12:   v = 8'd36;
      4'd13:   v = 8'd44;
      4'd14:   v = 8'd52;
      default: v = 8'd63;
    endcase
    return v;
  endfunction

  function automatic logic [AddrW-1:0] level_reg(input logic [ChW-1:0] ch);
    logic [AddrW-1:0] a;
    case (ch)
      2'd0:    a = 9'h14D;
      2'd1:    a = 9'h153;
      2'd2:    a = 9'h154;
      default: a = 9'h155;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> design/fm_channel_pitch_volume_writer.sv
// Channel   | Direction | Handshake        | Payload
// in_       | input     | valid / stall    | req_type, channel, frequency_hz, volume
// out_      | output    | valid / stall    | reg_addr, reg_data, last_write
// cfg_      | input     | valid / ready    | data: chip_present (bit 0)
//
// An item's first write is on the output after stages 1, 2 and 3 and the beat buffer;
// the pipe takes one item a cycle while nothing stalls.
// Sustained rate is set by the output port, one beat per cycle while out_stall is low:
// an item occupies it for one beat per write.
// Synchronous reset clears the key bytes and sets chip_present.
// Output stall backs up stage by stage into in_stall; empty stages still fill.
`default_nettype none

module fm_channel_pitch_volume_writer
  import fmcpvw_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,

  input  wire              in_valid,
  output logic             in_stall,
  input  wire              in_req_type,
  input  wire  [ChW-1:0]   in_channel,
  input  wire  [FreqW-1:0] in_frequency_hz,
  input  wire  [VolW-1:0]  in_volume,

  output logic             out_valid,
  input  wire              out_stall,
  output logic [AddrW-1:0] out_reg_addr,
  output logic [DataW-1:0] out_reg_data,
  output logic             out_last_write,

  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire              cfg_data
);

  logic chip_present_r;

  // stage 1: input register
  logic             s1_v_r;
  req_t             s1_type_r;
  logic [ChW-1:0]   s1_ch_r;
  logic [FreqW-1:0] s1_freq_r;
  logic [VolW-1:0]  s1_vol_r;

  // stage 2: block select, reciprocal multiply
  logic             s2_v_r;
  req_t             s2_type_r;
  logic [ChW-1:0]   s2_ch_r;
  logic [VolW-1:0]  s2_vol_r;
  logic [BlkW-1:0]  s2_bm1_r;
  logic [NumW-1:0]  s2_num_r;
  logic [QW-1:0]    s2_q_r;

  // stage 3: quotient correction
  logic             s3_v_r;
  req_t             s3_type_r;
  logic [ChW-1:0]   s3_ch_r;
  logic [VolW-1:0]  s3_vol_r;
  logic [BlkW-1:0]  s3_bm1_r;
  logic [FnumW-1:0] s3_fnum_r;

  // output beat buffer
  beat_t      beat_r [2];
  logic       head_r;
  logic [1:0] cnt_r;

  logic [DataW-1:0] key_r [CHANNELS];

  logic en1, en2, en3, pop, em_take;

  assign cfg_ready = 1'b1;

  assign pop     = (cnt_r != 2'd0) && !out_stall;
  assign em_take = s3_v_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop));
  assign en3     = !s3_v_r || em_take;
  assign en2     = !s2_v_r || en3;
  assign en1     = !s1_v_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_present_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      chip_present_r <= cfg_data;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_type_r <= req_t'(in_req_type);
      s1_ch_r   <= in_channel;
      s1_freq_r <= in_frequency_hz;
      s1_vol_r  <= in_volume;
    end
  end

  // stage 2
  logic [BlkW-1:0]      bm1_nxt;
  logic [FreqW+18:0]    num_full;
  logic [NumW-1:0]      num_nxt;
  logic [ProdW-1:0]     prod;

  always_comb begin
    if (s1_freq_r > Thr7) begin
      bm1_nxt = 3'd7;
    end else if (s1_freq_r > Thr6) begin
      bm1_nxt = 3'd6;
    end else if (s1_freq_r > Thr5) begin
      bm1_nxt = 3'd5;
    end else if (s1_freq_r > Thr4) begin
      bm1_nxt = 3'd4;
    end else if (s1_freq_r > Thr3) begin
      bm1_nxt = 3'd3;
    end else if (s1_freq_r > Thr2) begin
      bm1_nxt = 3'd2;
    end else if (s1_freq_r > Thr1) begin
      bm1_nxt = 3'd1;
    end else begin
      bm1_nxt = 3'd0;
    end
    // freq << (20 - block) == (freq << 19) >> (block - 1)
    num_full = {s1_freq_r, 19'b0} >> bm1_nxt;
    num_nxt  = num_full[NumW-1:0];
    prod     = ProdW'(num_nxt) * ProdW'(Recip[RecipW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_v_r) begin
      s2_type_r <= s1_type_r;
      s2_ch_r   <= s1_ch_r;
      s2_vol_r  <= s1_vol_r;
      s2_bm1_r  <= bm1_nxt;
      s2_num_r  <= num_nxt;
      s2_q_r    <= prod[ProdW-1:RecipShift];
    end
  end

  // stage 3: estimate is exact or one low
  logic [RemW-1:0]  qd;
  logic [RemW-1:0]  rem;
  logic [QW-1:0]    q_fix;

  always_comb begin
    qd    = RemW'(s2_q_r) * RemW'(Divisor);
    rem   = RemW'(s2_num_r) - qd;
    q_fix = s2_q_r + QW'(rem >= RemW'(Divisor));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_v_r) begin
      s3_type_r <= s2_type_r;
      s3_ch_r   <= s2_ch_r;
      s3_vol_r  <= s2_vol_r;
      s3_bm1_r  <= s2_bm1_r;
      s3_fnum_r <= q_fix[FnumW-1:0];
    end
  end

  // write planning and key byte update
  logic             ch_ok;
  logic [DataW-1:0] kb;
  logic [DataW-1:0] kb_nxt;
  logic             kb_wr;
  beat_t            b0_nxt, b1_nxt;
  logic [1:0]       n_nxt;
  logic [AddrW-1:0] key_addr;

  always_comb begin
    ch_ok    = ({1'b0, s3_ch_r} < (ChW + 1)'(CHANNELS));
    kb       = key_r[s3_ch_r];
    key_addr = KeyBase + AddrW'(s3_ch_r);
    kb_nxt   = kb;
    kb_wr    = 1'b0;
    n_nxt    = 2'd0;
    b0_nxt   = '0;
    b1_nxt   = '0;
    if (ch_ok) begin
      if (s3_type_r == REQ_FREQ) begin
        kb_nxt = {2'b00, kb[5], s3_bm1_r, s3_fnum_r[9:8]};
        kb_wr  = 1'b1;
        b0_nxt = '{addr: FnumLoBase + AddrW'(s3_ch_r), data: s3_fnum_r[7:0], last: 1'b0};
        b1_nxt = '{addr: key_addr, data: kb_nxt, last: 1'b1};
        n_nxt  = 2'd2;
      end else if (s3_vol_r == '0) begin
        kb_nxt = kb & KeyOffMask;
        kb_wr  = 1'b1;
        b0_nxt = '{addr: key_addr, data: kb_nxt, last: 1'b1};
        n_nxt  = 2'd1;
      end else if (!kb[5]) begin
        kb_nxt = kb | KeyOnMask;
        kb_wr  = 1'b1;
        b0_nxt = '{addr: key_addr, data: kb_nxt, last: 1'b0};
        b1_nxt = '{addr: level_reg(s3_ch_r), data: atten_lut(~s3_vol_r[7:4]), last: 1'b1};
        n_nxt  = 2'd2;
      end else begin
        b0_nxt = '{addr: level_reg(s3_ch_r), data: atten_lut(~s3_vol_r[7:4]), last: 1'b1};
        n_nxt  = 2'd1;
      end
    end
    if (!chip_present_r) begin
      n_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        key_r[i] <= '0;
      end
    end else if (em_take && kb_wr) begin
      key_r[s3_ch_r] <= kb_nxt;
    end
  end

  // beat buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      head_r <= 1'b0;
    end else if (em_take) begin
      cnt_r  <= n_nxt;
      head_r <= 1'b0;
    end else if (pop) begin
      cnt_r  <= cnt_r - 2'd1;
      head_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (em_take) begin
      beat_r[0] <= b0_nxt;
      beat_r[1] <= b1_nxt;
    end
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_reg_addr   = beat_r[head_r].addr;
  assign out_reg_data   = beat_r[head_r].data;
  assign out_last_write = beat_r[head_r].last;

`ifndef SYNTHESIS
  a_last_beat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> out_last_write)
    else $error("final beat without last_write");

  a_two_beats_from_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!head_r && !out_last_write))
    else $error("two pending beats not starting at slot 0");

  a_key_on_after_volume: assert property (@(posedge clk) disable iff (!rst_n)
    (em_take && ch_ok && (s3_type_r == REQ_VOL) && (s3_vol_r != '0))
      |=> key_r[$past(s3_ch_r)][5])
    else $error("key-on not set after nonzero volume");
`endif

endmodule

`default_nettype wire

>>> verif/fm_channel_pitch_volume_writer_checker.sv
module fm_channel_pitch_volume_writer_checker
  import fmcpvw_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,

  input  wire              in_valid,
  input  wire              in_stall,
  input  wire              in_req_type,
  input  wire  [ChW-1:0]   in_channel,
  input  wire  [FreqW-1:0] in_frequency_hz,
  input  wire  [VolW-1:0]  in_volume,

  input  wire              out_valid,
  input  wire              out_stall,
  input  wire  [AddrW-1:0] out_reg_addr,
  input  wire  [DataW-1:0] out_reg_data,
  input  wire              out_last_write,

  input  wire              cfg_valid,
  input  wire              cfg_ready,
  input  wire              cfg_data,

  output int               mismatches,
  output int               pending,
  output int               writes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [DataW-1:0] AttenSteps [16] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd8, 8'd10,
    8'd12, 8'd16, 8'd20, 8'd28, 8'd36, 8'd44, 8'd52, 8'd63
  };
  localparam logic [AddrW-1:0] LevelAddr [4] = '{9'h14D, 9'h153, 9'h154, 9'h155};

  logic [DataW-1:0] key_byte [CHANNELS];
  logic             chip_on;
  beat_t            expected_writes [$];

  task automatic report_mismatch(input string what);
    if (mismatches < 200) $display("checker: %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic predict_writes(input req_t kind, input logic [ChW-1:0] ch,
                                input logic [FreqW-1:0] hz, input logic [VolW-1:0] vol);
    beat_t            w [2];
    int               n;
    int unsigned      blk;
    longint unsigned  scaled;
    logic [FnumW-1:0] fnum;
    logic [DataW-1:0] kb;
    n  = 0;
    kb = key_byte[ch];
    if (kind == REQ_FREQ) begin
      if (hz > Thr7)      blk = 8;
      else if (hz > Thr6) blk = 7;
      else if (hz > Thr5) blk = 6;
      else if (hz > Thr4) blk = 5;
      else if (hz > Thr3) blk = 4;
      else if (hz > Thr2) blk = 3;
      else if (hz > Thr1) blk = 2;
      else                blk = 1;
      scaled = 64'(hz) << (20 - blk);
      fnum   = FnumW'(scaled / 64'd49716);
      kb     = (kb & KeyOnMask) | {3'b000, 3'(blk - 1), fnum[9:8]};
      w[0]   = '{FnumLoBase + AddrW'(ch), fnum[7:0], 1'b0};
      w[1]   = '{KeyBase + AddrW'(ch), kb, 1'b0};
      n      = 2;
    end else if (vol == '0) begin
      kb   = kb & ~KeyOnMask;
      w[0] = '{KeyBase + AddrW'(ch), kb, 1'b0};
      n    = 1;
    end else begin
      if ((kb & KeyOnMask) == '0) begin
        kb   = kb | KeyOnMask;
        w[n] = '{KeyBase + AddrW'(ch), kb, 1'b0};
        n++;
      end
      w[n] = '{LevelAddr[ch], AttenSteps[4'd15 - vol[VolW-1:4]], 1'b0};
      n++;
    end
    key_byte[ch] = kb;
    if (chip_on) begin
      w[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_writes.push_back(w[i]);
    end
  endtask

  task automatic check_write();
    beat_t want;
    if (expected_writes.size() == 0) begin
      report_mismatch($sformatf("unexpected write addr %h data %h last %b",
                                out_reg_addr, out_reg_data, out_last_write));
      return;
    end
    want = expected_writes.pop_front();
    writes_checked++;
    if (out_reg_addr !== want.addr)
      report_mismatch($sformatf("reg_addr %h, expected %h", out_reg_addr, want.addr));
    if (out_reg_data !== want.data)
      report_mismatch($sformatf("reg_data %h, expected %h (addr %h)",
                                out_reg_data, want.data, want.addr));
    if (out_last_write !== want.last)
      report_mismatch($sformatf("last_write %b, expected %b (addr %h)",
                                out_last_write, want.last, want.addr));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (key_byte[i]) key_byte[i] = '0;
      chip_on = 1'b1;
      expected_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) chip_on = cfg_data;
      if (in_valid && !in_stall)
        predict_writes(req_t'(in_req_type), in_channel, in_frequency_hz, in_volume);
      if (out_valid && !out_stall) check_write();
    end
    pending = expected_writes.size();
  end

endmodule

>>> verif/tb_fm_channel_pitch_volume_writer.sv
module tb_fm_channel_pitch_volume_writer;
  import fmcpvw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BlockSteps [7] = '{97, 194, 388, 776, 1552, 3104, 6208};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_req_type;
  logic [ChW-1:0]   in_channel;
  logic [FreqW-1:0] in_frequency_hz;
  logic [VolW-1:0]  in_volume;
  logic             out_valid;
  logic             out_stall;
  logic [AddrW-1:0] out_reg_addr;
  logic [DataW-1:0] out_reg_data;
  logic             out_last_write;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_data;

  int               mismatches;
  int               pending;
  int               writes_checked;
  int               requests_sent;
  int unsigned      stall_pct;
  int unsigned      hold_asks;

  fm_channel_pitch_volume_writer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_channel      (in_channel),
    .in_frequency_hz (in_frequency_hz),
    .in_volume       (in_volume),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg_addr    (out_reg_addr),
    .out_reg_data    (out_reg_data),
    .out_last_write  (out_last_write),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  fm_channel_pitch_volume_writer_checker writes_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_channel      (in_channel),
    .in_frequency_hz (in_frequency_hz),
    .in_volume       (in_volume),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg_addr    (out_reg_addr),
    .out_reg_data    (out_reg_data),
    .out_last_write  (out_last_write),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .writes_checked  (writes_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls at the phase's rate, or a long hold-off on request
  initial begin
    int unsigned left;
    int unsigned seen;
    left      = 0;
    seen      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != seen) begin
        seen = hold_asks;
        left = 400;
      end
      if (left != 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_request(input req_t kind, input logic [ChW-1:0] ch,
                              input logic [FreqW-1:0] hz, input logic [VolW-1:0] vol);
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_channel      <= ch;
    in_frequency_hz <= hz;
    in_volume       <= vol;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_request();
    req_t             kind;
    logic [FreqW-1:0] hz;
    logic [VolW-1:0]  vol;
    kind = req_t'($urandom_range(1));
    case ($urandom_range(9))
      0, 1, 2, 3, 4: hz = FreqW'($urandom);
      5, 6, 7:       hz = FreqW'(BlockSteps[$urandom_range(6)] + $urandom_range(4) - 2);
      default:       hz = FreqW'($urandom_range(200));
    endcase
    case ($urandom_range(7))
      0, 1:    vol = '0;
      2:       vol = VolW'($urandom_range(15));
      default: vol = VolW'($urandom);
    endcase
    send_request(kind, ChW'($urandom_range(CHANNELS - 1)), hz, vol);
  endtask

  task automatic run_random(input int count, input int max_gap);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(12, 1);
        gap   = $urandom_range(max_gap);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      send_random_request();
      burst--;
    end
  endtask

  // covers requests in flight that produce no writes
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_chip_present(input logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = 1'b0;
    in_channel      = '0;
    in_frequency_hz = '0;
    in_volume       = '0;
    cfg_valid       = 1'b0;
    cfg_data        = 1'b0;
    requests_sent   = 0;
    stall_pct       = 0;
    hold_asks       = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_chip_present(1'b1);
    @(negedge clk);

    // block thresholds, frequency extremes, key-on on every channel, key-off on channel 0
    send_request(REQ_FREQ, 2'd0, 14'd0, 8'd0);
    send_request(REQ_FREQ, 2'd0, 14'd97, 8'd0);
    send_request(REQ_FREQ, 2'd0, 14'd98, 8'd0);
    send_request(REQ_FREQ, 2'd0, 14'd16383, 8'd0);
    send_request(REQ_VOL, 2'd0, 14'd0, 8'd255);
    send_request(REQ_VOL, 2'd0, 14'd16383, 8'd1);
    send_request(REQ_FREQ, 2'd0, 14'd1, 8'd255);
    send_request(REQ_VOL, 2'd0, 14'd0, 8'd0);
    send_request(REQ_VOL, 2'd0, 14'd0, 8'd0);
    send_request(REQ_FREQ, 2'd1, 14'd194, 8'd0);
    send_request(REQ_FREQ, 2'd1, 14'd195, 8'd0);
    send_request(REQ_FREQ, 2'd1, 14'd388, 8'd0);
    send_request(REQ_FREQ, 2'd1, 14'd389, 8'd0);
    send_request(REQ_VOL, 2'd1, 14'd0, 8'd16);
    send_request(REQ_VOL, 2'd1, 14'd0, 8'd240);
    send_request(REQ_FREQ, 2'd2, 14'd776, 8'd0);
    send_request(REQ_FREQ, 2'd2, 14'd777, 8'd0);
    send_request(REQ_FREQ, 2'd2, 14'd1552, 8'd0);
    send_request(REQ_FREQ, 2'd2, 14'd1553, 8'd0);
    send_request(REQ_VOL, 2'd2, 14'd0, 8'd128);
    send_request(REQ_FREQ, 2'd3, 14'd3104, 8'd0);
    send_request(REQ_FREQ, 2'd3, 14'd3105, 8'd0);
    send_request(REQ_FREQ, 2'd3, 14'd6208, 8'd0);
    send_request(REQ_FREQ, 2'd3, 14'd6209, 8'd0);
    send_request(REQ_VOL, 2'd3, 14'd0, 8'd15);

    stall_pct = 30;
    run_random(500, 6);

    // long receiver hold-off while the sender keeps pushing
    @(posedge clk);
    hold_asks++;
    @(negedge clk);
    run_random(80, 0);

    wait_drained();
    write_chip_present(1'b0);
    @(negedge clk);
    stall_pct = 20;
    run_random(150, 4);
    wait_drained();
    write_chip_present(1'b1);
    @(negedge clk);

    stall_pct = 70;
    run_random(500, 8);

    stall_pct = 0;
    run_random(300, 0);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("summary: %0d requests accepted, %0d register writes checked", requests_sent,
             writes_checked);
    $display("summary: phases with chip absent, long output hold-off and varied stall rates");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
